@@ src/stl_pkg.sv @@
package stl_pkg;

    // Field and datapath widths
    localparam int FIELD_W   = 16;
    localparam int TORQUE_W  = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int MUL_A_W   = 30;
    localparam int MUL_B_W   = 13;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int WIN_W     = PROD_W + 1;
    localparam int RATE_W    = 14;

    // Below this speed magnitude the car counts as stopped
    localparam logic signed [FIELD_W-1:0] STILL_SPEED = 16'sd30;

    // Rounding of the Q1.15 fraction product and of the 1/256 window bounds
    localparam logic [26:0] FRAC_HALF = 27'd16384;
    localparam logic [19:0] WIN_HALF  = 20'd128;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TORQUE_MAX        = 3'd0,
        CFG_DRIVER_ALLOWANCE  = 3'd1,
        CFG_DRIVER_FACTOR     = 3'd2,
        CFG_DRIVER_MULTIPLIER = 3'd3,
        CFG_RATE_UP           = 3'd4,
        CFG_RATE_DOWN         = 3'd5,
        CFG_ENABLE_STEP_LIMIT = 3'd6,
        CFG_HOLD_STEP_LIMIT   = 3'd7
    } cfg_reg_t;

    // Sequencer steps
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAC,
        ST_DRV,
        ST_WHI,
        ST_WLO,
        ST_CLAMP,
        ST_RATE,
        ST_DONE
    } state_t;

endpackage

@@ src/stl_if.sv @@
interface stl_in_if;
    logic                     valid;
    logic                     ready;
    logic                     steer_request;
    logic                     power_steer_ok;
    logic                     standstill_flag;
    logic signed [15:0]       speed_cms;
    logic                     torque_given;
    logic signed [15:0]       torque_request;
    logic signed [15:0]       steer_fraction;
    logic signed [15:0]       drv_torque;

    modport source (
        output valid, steer_request, power_steer_ok, standstill_flag, speed_cms,
               torque_given, torque_request, steer_fraction, drv_torque,
        input  ready
    );
    modport sink (
        input  valid, steer_request, power_steer_ok, standstill_flag, speed_cms,
               torque_given, torque_request, steer_fraction, drv_torque,
        output ready
    );
endinterface

interface stl_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] applied_torque;
    logic               assist_enable;

    modport source (
        output valid, applied_torque, assist_enable,
        input  ready
    );
    modport sink (
        input  valid, applied_torque, assist_enable,
        output ready
    );
endinterface

@@ src/stl_mul.sv @@
module stl_mul
    import stl_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // Register every product before it is used
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

@@ src/steer_torque_limiter.sv @@
// Channel   Role   Beat contents
// period    sink   steering flags, speed, torque request, fraction, driver torque
// torque    source applied torque command and assist enable flag
// cfg_*     write  register index and data, no read-back
//
// A beat is accepted in the idle state and then runs seven sequencer steps, four
// of them passes through the one shared multiplier (fraction, driver scale and
// the two window gains). A result waiting in the output register holds the
// final step until it is taken. Reset restores the register defaults and
// clears the last torque and both step counters. No clearing pass is needed.
module steer_torque_limiter
    import stl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    stl_in_if.sink               period,
    stl_out_if.source            torque,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers
    logic [10:0] torque_max_reg;
    logic [10:0] allowance_reg;
    logic [11:0] factor_reg;
    logic [3:0]  multiplier_reg;
    logic [7:0]  rate_up_reg;
    logic [7:0]  rate_down_reg;
    logic [15:0] enable_limit_reg;
    logic [15:0] hold_limit_reg;

    // Sequencer and state
    state_t state_reg, state_next;
    logic signed [TORQUE_W-1:0] last_torque_reg, last_torque_next;
    logic [15:0] enable_steps_reg, enable_steps_next;
    logic [15:0] hold_steps_reg, hold_steps_next;

    // Captured beat and intermediate results
    logic                       steer_reg;
    logic                       given_reg;
    logic signed [15:0]         treq_reg;
    logic signed [15:0]         frac_reg;
    logic signed [15:0]         drv_reg;
    logic signed [15:0]         want_reg;
    logic signed [27:0]         dq_reg;
    logic [10:0]                hir_reg;
    logic signed [TORQUE_W-1:0] lim_reg;
    logic signed [TORQUE_W-1:0] rate_reg;

    // Output register
    logic                       out_valid_reg;
    logic signed [TORQUE_W-1:0] out_torque_reg;
    logic                       out_enable_reg;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic in_fire;
    logic out_free;
    logic moving;

    stl_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign period.ready = (state_reg == ST_IDLE);
    assign in_fire      = period.valid && period.ready;
    assign out_free     = !out_valid_reg || torque.ready;
    assign moving       = !((period.speed_cms > -STILL_SPEED) &&
                            (period.speed_cms < STILL_SPEED));

    assign torque.valid          = out_valid_reg;
    assign torque.applied_torque = out_torque_reg;
    assign torque.assist_enable  = out_enable_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            torque_max_reg   <= 11'd300;
            allowance_reg    <= 11'd80;
            factor_reg       <= 12'd256;
            multiplier_reg   <= 4'd3;
            rate_up_reg      <= 8'd4;
            rate_down_reg    <= 8'd10;
            enable_limit_reg <= 16'd5900;
            hold_limit_reg   <= 16'd95;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_TORQUE_MAX:        torque_max_reg   <= cfg_data[10:0];
                CFG_DRIVER_ALLOWANCE:  allowance_reg    <= cfg_data[10:0];
                CFG_DRIVER_FACTOR:     factor_reg       <= cfg_data[11:0];
                CFG_DRIVER_MULTIPLIER: multiplier_reg   <= cfg_data[3:0];
                CFG_RATE_UP:           rate_up_reg      <= cfg_data[7:0];
                CFG_RATE_DOWN:         rate_down_reg    <= cfg_data[7:0];
                CFG_ENABLE_STEP_LIMIT: enable_limit_reg <= cfg_data;
                CFG_HOLD_STEP_LIMIT:   hold_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_FRAC;
            ST_FRAC:  state_next = ST_DRV;
            ST_DRV:   state_next = ST_WHI;
            ST_WHI:   state_next = ST_WLO;
            ST_WLO:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_RATE;
            ST_RATE:  state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Steer multiplier operands by step
    logic signed [27:0]        dq_now;
    logic signed [MUL_A_W-1:0] allow_q;

    assign dq_now  = prod[27:0];
    assign allow_q = $signed({11'd0, allowance_reg, 8'd0});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_FRAC:
            begin
                mul_a = MUL_A_W'(frac_reg);
                mul_b = $signed({2'd0, torque_max_reg});
            end
            ST_DRV:
            begin
                mul_a = MUL_A_W'(drv_reg);
                mul_b = $signed({1'b0, factor_reg});
            end
            ST_WHI:
            begin
                mul_a = allow_q + MUL_A_W'(dq_now);
                mul_b = $signed({9'd0, multiplier_reg});
            end
            ST_WLO:
            begin
                mul_a = MUL_A_W'(dq_reg) - allow_q;
                mul_b = $signed({9'd0, multiplier_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round the fraction product half away from zero
    logic signed [26:0] frac_prod;
    logic [26:0]        frac_abs;
    logic [26:0]        frac_rnd;
    logic [10:0]        frac_mag;
    logic signed [15:0] want_frac;

    assign frac_prod = prod[26:0];
    assign frac_abs  = frac_prod[26] ? 27'(-frac_prod) : 27'(frac_prod);
    assign frac_rnd  = frac_abs + FRAC_HALF;
    assign frac_mag  = frac_rnd[25:15];
    assign want_frac = frac_prod[26] ? -$signed({5'd0, frac_mag})
                                     : $signed({5'd0, frac_mag});

    // Clip the upper window bound to 0..max and round
    logic signed [WIN_W-1:0] tmax_q;
    logic signed [WIN_W-1:0] hi_sum;
    logic [18:0]             hi_clip;
    logic [19:0]             hi_rnd;

    assign tmax_q = $signed({25'd0, torque_max_reg, 8'd0});
    assign hi_sum = tmax_q + WIN_W'(prod);

    always_comb
    begin
        priority if (hi_sum > tmax_q)
            hi_clip = tmax_q[18:0];
        else if (hi_sum < 0)
            hi_clip = '0;
        else
            hi_clip = hi_sum[18:0];
    end

    assign hi_rnd = {1'b0, hi_clip} + WIN_HALF;

    // Clip the lower window bound to -max..0 and round its magnitude
    logic signed [WIN_W-1:0] lo_sum;
    logic signed [WIN_W-1:0] lo_neg;
    logic [18:0]             lo_clip;
    logic [19:0]             lo_rnd;
    logic [10:0]             lor;
    logic signed [16:0]      lo_bound;
    logic signed [16:0]      hi_bound;
    logic signed [16:0]      want_ext;
    logic signed [16:0]      lim_now;

    assign lo_sum = WIN_W'(prod) - tmax_q;
    assign lo_neg = -lo_sum;

    always_comb
    begin
        priority if (lo_neg > tmax_q)
            lo_clip = tmax_q[18:0];
        else if (lo_neg < 0)
            lo_clip = '0;
        else
            lo_clip = lo_neg[18:0];
    end

    assign lo_rnd   = {1'b0, lo_clip} + WIN_HALF;
    assign lor      = lo_rnd[18:8];
    assign lo_bound = -$signed({6'd0, lor});
    assign hi_bound = $signed({6'd0, hir_reg});
    assign want_ext = 17'(want_reg);

    always_comb
    begin
        priority if (want_ext < lo_bound)
            lim_now = lo_bound;
        else if (want_ext > hi_bound)
            lim_now = hi_bound;
        else
            lim_now = want_ext;
    end

    // Rate-limit against the last torque
    logic signed [RATE_W-1:0] last_ext;
    logic signed [RATE_W-1:0] up_ext;
    logic signed [RATE_W-1:0] dn_ext;
    logic signed [RATE_W-1:0] lim_ext;
    logic signed [RATE_W-1:0] rate_lo;
    logic signed [RATE_W-1:0] rate_hi;
    logic signed [RATE_W-1:0] rate_now;

    assign last_ext = RATE_W'(last_torque_reg);
    assign up_ext   = $signed({6'd0, rate_up_reg});
    assign dn_ext   = $signed({6'd0, rate_down_reg});
    assign lim_ext  = RATE_W'(lim_reg);

    always_comb
    begin
        if (last_ext > 0)
        begin
            rate_lo = last_ext - dn_ext;
            if (rate_lo < -up_ext)
                rate_lo = -up_ext;
            rate_hi = last_ext + up_ext;
        end
        else
        begin
            rate_lo = last_ext - up_ext;
            rate_hi = last_ext + dn_ext;
            if (rate_hi > up_ext)
                rate_hi = up_ext;
        end
        priority if (lim_ext < rate_lo)
            rate_now = rate_lo;
        else if (lim_ext > rate_hi)
            rate_now = rate_hi;
        else
            rate_now = lim_ext;
    end

    // Hold the beat and step results
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            steer_reg <= period.steer_request && period.power_steer_ok &&
                         !period.standstill_flag && moving;
            given_reg <= period.torque_given;
            treq_reg  <= period.torque_request;
            frac_reg  <= period.steer_fraction;
            drv_reg   <= period.drv_torque;
        end
        if (state_reg == ST_DRV)
            want_reg <= given_reg ? treq_reg : want_frac;
        if (state_reg == ST_WHI)
            dq_reg <= dq_now;
        if (state_reg == ST_WLO)
            hir_reg <= hi_rnd[18:8];
        if (state_reg == ST_CLAMP)
            lim_reg <= lim_now[TORQUE_W-1:0];
        if (state_reg == ST_RATE)
            rate_reg <= rate_now[TORQUE_W-1:0];
    end

    // Count enable and hold steps, nudge a held torque toward zero
    logic signed [TORQUE_W-1:0] apply_base;
    logic [16:0]                enable_cnt;
    logic [16:0]                hold_cnt;
    logic                       enable_now;
    logic                       commit;

    assign apply_base = steer_reg ? rate_reg : '0;
    assign enable_cnt = {1'b0, enable_steps_reg} + 17'd1;
    assign hold_cnt   = {1'b0, hold_steps_reg} + 17'd1;
    assign commit     = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        last_torque_next  = apply_base;
        enable_now        = 1'b0;
        enable_steps_next = enable_steps_reg;
        hold_steps_next   = hold_steps_reg;
        priority if (apply_base == '0)
            enable_steps_next = '0;
        else if (enable_cnt >= {1'b0, enable_limit_reg})
            enable_steps_next = '0;
        else
        begin
            enable_steps_next = enable_cnt[15:0];
            enable_now        = 1'b1;
            if (last_torque_reg == apply_base)
            begin
                if (hold_cnt > {1'b0, hold_limit_reg})
                begin
                    last_torque_next = apply_base[TORQUE_W-1] ? apply_base + 12'sd1
                                                              : apply_base - 12'sd1;
                    hold_steps_next  = '0;
                end
                else
                    hold_steps_next = hold_cnt[15:0];
            end
            else
                hold_steps_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_torque_reg  <= '0;
            enable_steps_reg <= '0;
            hold_steps_reg   <= '0;
        end
        else if (commit)
        begin
            last_torque_reg  <= last_torque_next;
            enable_steps_reg <= enable_steps_next;
            hold_steps_reg   <= hold_steps_next;
        end
    end

    // Load the output beat, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (torque.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_torque_reg <= last_torque_next;
            out_enable_reg <= enable_now;
        end
    end

    // Checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_FRAC)
        else $error("accepted beat did not start the sequencer");

    a_torque_range: assert property (@(posedge clk) disable iff (!rst_n)
        torque.valid |-> torque.applied_torque != -12'sd2048)
        else $error("applied torque outside the window");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (torque.valid && !torque.ready) |=>
            (torque.valid && $stable(torque.applied_torque) &&
             $stable(torque.assist_enable)))
        else $error("stalled torque beat changed before it was taken");

    a_last_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $past(commit) |-> (torque.valid && torque.applied_torque == last_torque_reg))
        else $error("stored torque differs from delivered beat");

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import stl_pkg::*;

    // One steering period as driven on the period channel
    typedef struct packed {
        logic                       steer_request;
        logic                       power_steer_ok;
        logic                       standstill_flag;
        logic signed [FIELD_W-1:0]  speed_cms;
        logic                       torque_given;
        logic signed [FIELD_W-1:0]  torque_request;
        logic signed [FIELD_W-1:0]  steer_fraction;
        logic signed [FIELD_W-1:0]  drv_torque;
    } period_t;

    // One beat of the torque channel
    typedef struct packed {
        logic signed [TORQUE_W-1:0] applied_torque;
        logic                       assist_enable;
    } torque_res_t;

    typedef struct packed {
        period_t     p;
        logic        typed;
        torque_res_t res;
    } dir_row_t;

    typedef struct packed {
        logic [10:0] torque_max;
        logic [10:0] driver_allowance;
        logic [11:0] driver_factor;
        logic [3:0]  driver_multiplier;
        logic [7:0]  rate_up;
        logic [7:0]  rate_down;
        logic [15:0] enable_step_limit;
        logic [15:0] hold_step_limit;
    } limiter_regs_t;

    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int NUM_REGS      = 8;
    localparam int NUM_PHASES    = 5;
    localparam int RAND_TOTAL    = 1000;
    localparam int DIR_N         = 19;

    // Sender gap and receiver stall, in percent, per idling mode
    localparam int IDLE_GAP   [3] = '{13, 83, 0};
    localparam int IDLE_STALL [3] = '{83, 13, 0};

    // Register settings per random phase, in register index order
    localparam int PHASE_CFG [NUM_PHASES][NUM_REGS] = '{
        '{2047, 2047, 4095, 15, 255, 255, 65535, 65535},
        '{0,    0,    0,    0,  0,   0,   1,     0},
        '{500,  100,  384,  2,  20,  40,  8,     3},
        '{1200, 300,  128,  5,  60,  30,  40,    0},
        '{300,  80,   256,  3,  4,   10,  5900,  95}
    };
    localparam int PHASE_ITEMS [NUM_PHASES] = '{200, 60, 300, 260, 180};

    // Directed periods at the reset register values, starting from a cleared state
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // not requested, power steering refused, standstill
        '{'{1'b0, 1'b1, 1'b0, 16'sd1000, 1'b1, 16'sd100, 16'sd0, 16'sd0}, 1'b1,
          '{12'sd0, 1'b0}},
        '{'{1'b1, 1'b0, 1'b0, 16'sd1000, 1'b1, 16'sd100, 16'sd0, 16'sd0}, 1'b1,
          '{12'sd0, 1'b0}},
        '{'{1'b1, 1'b1, 1'b1, 16'sd1000, 1'b1, 16'sd100, 16'sd0, 16'sd0}, 1'b1,
          '{12'sd0, 1'b0}},
        // just below the moving threshold either way
        '{'{1'b1, 1'b1, 1'b0, 16'sd29, 1'b1, 16'sd100, 16'sd0, 16'sd0}, 1'b1,
          '{12'sd0, 1'b0}},
        '{'{1'b1, 1'b1, 1'b0, -16'sd29, 1'b1, 16'sd100, 16'sd0, 16'sd0}, 1'b1,
          '{12'sd0, 1'b0}},
        // at the threshold: ramp limited by rate_up
        '{'{1'b1, 1'b1, 1'b0, 16'sd30, 1'b1, 16'sd100, 16'sd0, 16'sd0}, 1'b1,
          '{12'sd4, 1'b1}},
        '{'{1'b1, 1'b1, 1'b0, -16'sd30, 1'b1, 16'sd100, 16'sd0, 16'sd0}, 1'b1,
          '{12'sd8, 1'b1}},
        // extreme direct requests and speeds
        '{'{1'b1, 1'b1, 1'b0, 16'sh7FFF, 1'b1, 16'sh7FFF, 16'sd0, 16'sd0}, 1'b1,
          '{12'sd12, 1'b1}},
        '{'{1'b1, 1'b1, 1'b0, 16'sh8000, 1'b1, 16'sh8000, 16'sd0, 16'sd0}, 1'b1,
          '{12'sd2, 1'b1}},
        // fraction requests at the extremes and zero
        '{'{1'b1, 1'b1, 1'b0, 16'sd500, 1'b0, 16'sd0, 16'sh7FFF, 16'sd0}, 1'b0,
          '{12'sd0, 1'b0}},
        '{'{1'b1, 1'b1, 1'b0, 16'sd500, 1'b0, 16'sd0, 16'sh8000, 16'sd0}, 1'b0,
          '{12'sd0, 1'b0}},
        '{'{1'b1, 1'b1, 1'b0, 16'sd500, 1'b0, 16'sd0, 16'sd0, 16'sd0}, 1'b0,
          '{12'sd0, 1'b0}},
        // driver torque at the extremes closes one side of the window, then two moderate ones
        '{'{1'b1, 1'b1, 1'b0, 16'sd500, 1'b1, -16'sd1000, 16'sd0, 16'sh7FFF}, 1'b0,
          '{12'sd0, 1'b0}},
        '{'{1'b1, 1'b1, 1'b0, 16'sd500, 1'b1, 16'sd1000, 16'sd0, 16'sh8000}, 1'b0,
          '{12'sd0, 1'b0}},
        '{'{1'b1, 1'b1, 1'b0, 16'sd500, 1'b1, 16'sd500, 16'sd0, 16'sd100}, 1'b0,
          '{12'sd0, 1'b0}},
        '{'{1'b1, 1'b1, 1'b0, 16'sd500, 1'b1, -16'sd500, 16'sd0, -16'sd100}, 1'b0,
          '{12'sd0, 1'b0}},
        // all ones, stopped
        '{'{1'b1, 1'b1, 1'b1, 16'shFFFF, 1'b1, 16'shFFFF, 16'shFFFF, 16'shFFFF}, 1'b1,
          '{12'sd0, 1'b0}},
        // tiny fractions round to zero and to one
        '{'{1'b1, 1'b1, 1'b0, 16'sd500, 1'b0, 16'sd0, -16'sd1, 16'sd0}, 1'b0,
          '{12'sd0, 1'b0}},
        '{'{1'b1, 1'b1, 1'b0, 16'sd500, 1'b0, 16'sd0, 16'sd55, 16'sd0}, 1'b0,
          '{12'sd0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    stl_in_if  period ();
    stl_out_if torque ();

    steer_torque_limiter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .period    (period.sink),
        .torque    (torque.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and state
    limiter_regs_t regs = '{11'd300, 11'd80, 12'd256, 4'd3, 8'd4, 8'd10, 16'd5900, 16'd95};
    longint        last_cmd   = 0;
    int unsigned   on_steps   = 0;
    int unsigned   same_steps = 0;

    torque_res_t   torque_q [$];
    int            fails      = 0;
    int            beats_in   = 0;
    int            assist_on  = 0;
    int            drops      = 0;
    int            nudges     = 0;
    int            gap_pct    = 0;
    int            stall_pct  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Work out the command for one period and advance the predicted state
    function automatic torque_res_t limit_torque(input period_t p);
        longint      want, prod, mag, m, a, dq, g, hi, lo, up, dn, rlo, rhi, cmd;
        int unsigned cnt, h;
        logic        moving;
        torque_res_t r;
        moving = !p.standstill_flag && !(p.speed_cms > -30 && p.speed_cms < 30);
        cmd = 0;
        r.assist_enable = 1'b0;
        if (p.steer_request && p.power_steer_ok && moving)
        begin
            if (p.torque_given)
                want = longint'(p.torque_request);
            else
            begin
                prod = longint'(p.steer_fraction) * longint'(regs.torque_max);
                mag  = (((prod < 0) ? -prod : prod) + 16384) >>> 15;
                want = (prod < 0) ? -mag : mag;
            end
            // driver window in 1/256 units, rounded half away from zero
            m  = longint'(regs.torque_max) * 256;
            a  = longint'(regs.driver_allowance) * 256;
            dq = longint'(p.drv_torque) * longint'(regs.driver_factor);
            g  = longint'(regs.driver_multiplier);
            hi = m + (a + dq) * g;
            lo = -m + (dq - a) * g;
            hi = clip(hi, 0, m);
            lo = clip(lo, -m, 0);
            want = clip(want, -((128 - lo) / 256), (hi + 128) / 256);
            // rate limit against the last command
            up = longint'(regs.rate_up);
            dn = longint'(regs.rate_down);
            if (last_cmd > 0)
            begin
                rlo = (last_cmd - dn < -up) ? -up : last_cmd - dn;
                rhi = last_cmd + up;
            end
            else
            begin
                rlo = last_cmd - up;
                rhi = (last_cmd + dn > up) ? up : last_cmd + dn;
            end
            cmd = clip(want, rlo, rhi);

            if (cmd == 0)
                on_steps = 0;
            else
            begin
                cnt = on_steps + 1;
                if (cnt >= regs.enable_step_limit)
                begin
                    on_steps = 0;
                    drops++;
                end
                else
                begin
                    on_steps = cnt & 32'hFFFF;
                    r.assist_enable = 1'b1;
                    if (last_cmd == cmd)
                    begin
                        h = same_steps + 1;
                        if (h > regs.hold_step_limit)
                        begin
                            cmd += (cmd < 0) ? 1 : -1;
                            same_steps = 0;
                            nudges++;
                        end
                        else
                            same_steps = h & 32'hFFFF;
                    end
                    else
                        same_steps = 0;
                end
            end
        end
        else
            on_steps = 0;
        last_cmd = cmd;
        if (r.assist_enable)
            assist_on++;
        r.applied_torque = cmd[TORQUE_W-1:0];
        return r;
    endfunction

    // Drive one period beat, hold it until taken, then log the expected command
    task automatic send_period(input period_t p, input logic typed, input torque_res_t typed_res);
        torque_res_t res;
        while ($urandom_range(99) < gap_pct)
        begin
            period.valid <= 1'b0;
            @(negedge clk);
        end
        period.valid           <= 1'b1;
        period.steer_request   <= p.steer_request;
        period.power_steer_ok  <= p.power_steer_ok;
        period.standstill_flag <= p.standstill_flag;
        period.speed_cms       <= p.speed_cms;
        period.torque_given    <= p.torque_given;
        period.torque_request  <= p.torque_request;
        period.steer_fraction  <= p.steer_fraction;
        period.drv_torque      <= p.drv_torque;
        @(posedge clk);
        while (!period.ready)
            @(posedge clk);
        res = limit_torque(p);
        torque_q.insert(torque_q.size(), typed ? typed_res : res);
        beats_in++;
        @(negedge clk);
    endtask

    // Randomly stall the torque receiver
    always @(negedge clk)
        torque.ready <= ($urandom_range(99) >= stall_pct);

    // Compare each torque beat with the oldest expectation
    always @(posedge clk)
    begin : check_torque
        torque_res_t want;
        if (torque.valid && torque.ready)
        begin
            if (torque_q.size() == 0)
            begin
                $error("torque beat with nothing expected: applied_torque %0d assist_enable %0d",
                       torque.applied_torque, torque.assist_enable);
                fails++;
            end
            else
            begin
                want = torque_q.pop_front();
                if (torque.applied_torque !== want.applied_torque)
                begin
                    $error("applied_torque: expected %0d, got %0d",
                           want.applied_torque, torque.applied_torque);
                    fails++;
                end
                if (torque.assist_enable !== want.assist_enable)
                begin
                    $error("assist_enable: expected %0d, got %0d",
                           want.assist_enable, torque.assist_enable);
                    fails++;
                end
            end
        end
    end

    // End the run if no beat moves on either channel for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((period.valid && period.ready) || (torque.valid && torque.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        period_t     p;
        torque_res_t none;
        int          aim_torque, aim_frac, aim_drv, span, spd, roll, done;
        logic        aim_given;
        none       = '0;
        aim_torque = 0;
        aim_frac   = 0;
        aim_drv    = 0;
        aim_given  = 1'b1;
        done       = 0;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        torque.ready           = 1'b0;
        period.valid           = 1'b0;
        period.steer_request   = 1'b0;
        period.power_steer_ok  = 1'b0;
        period.standstill_flag = 1'b0;
        period.speed_cms       = '0;
        period.torque_given    = 1'b0;
        period.torque_request  = '0;
        period.steer_fraction  = '0;
        period.drv_torque      = '0;

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed periods at the reset register values
        gap_pct   = IDLE_GAP[0];
        stall_pct = IDLE_STALL[0];
        for (int i = 0; i < DIR_N; i++)
            send_period(DIR_ROWS[i].p, DIR_ROWS[i].typed, DIR_ROWS[i].res);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // Drain and let the sequencer settle before touching the registers
            period.valid <= 1'b0;
            while (torque_q.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES)
                @(negedge clk);
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_we    <= 1'b1;
                cfg_index <= CFG_IDX_W'(i);
                cfg_data  <= CFG_W'(PHASE_CFG[ph][i]);
                case (cfg_reg_t'(i))
                    CFG_TORQUE_MAX:        regs.torque_max        = 11'(PHASE_CFG[ph][i]);
                    CFG_DRIVER_ALLOWANCE:  regs.driver_allowance  = 11'(PHASE_CFG[ph][i]);
                    CFG_DRIVER_FACTOR:     regs.driver_factor     = 12'(PHASE_CFG[ph][i]);
                    CFG_DRIVER_MULTIPLIER: regs.driver_multiplier = 4'(PHASE_CFG[ph][i]);
                    CFG_RATE_UP:           regs.rate_up           = 8'(PHASE_CFG[ph][i]);
                    CFG_RATE_DOWN:         regs.rate_down         = 8'(PHASE_CFG[ph][i]);
                    CFG_ENABLE_STEP_LIMIT: regs.enable_step_limit = 16'(PHASE_CFG[ph][i]);
                    CFG_HOLD_STEP_LIMIT:   regs.hold_step_limit   = 16'(PHASE_CFG[ph][i]);
                    default: ;
                endcase
                @(negedge clk);
            end
            cfg_we <= 1'b0;
            @(negedge clk);

            for (int n = 0; n < PHASE_ITEMS[ph]; n++)
            begin
                gap_pct   = IDLE_GAP[(done * 3) / RAND_TOTAL];
                stall_pct = IDLE_STALL[(done * 3) / RAND_TOTAL];
                span = int'(regs.torque_max) + 200;
                roll = $urandom_range(99);
                if (roll < 20)
                begin
                    // noise: every field at random, breaks running sequences
                    p.steer_request   = 1'($urandom_range(1));
                    p.power_steer_ok  = 1'($urandom_range(1));
                    p.standstill_flag = 1'($urandom_range(1));
                    p.speed_cms       = (roll < 8) ? FIELD_W'($urandom_range(0, 60) - 30)
                                                   : FIELD_W'($urandom);
                    p.torque_given    = 1'($urandom_range(1));
                    p.torque_request  = FIELD_W'($urandom);
                    p.steer_fraction  = FIELD_W'($urandom);
                    p.drv_torque      = FIELD_W'($urandom);
                end
                else
                begin
                    // steering sequence: hold targets so that the ramp settles and holds
                    if ($urandom_range(99) < 8)
                    begin
                        if ($urandom_range(99) < 70)
                            aim_torque = int'($urandom_range(0, 2 * span)) - span;
                        else
                            aim_torque = int'($signed(FIELD_W'($urandom)));
                        aim_frac = int'($signed(FIELD_W'($urandom)));
                        if ($urandom_range(99) < 25)
                            aim_given = 1'($urandom_range(1));
                    end
                    if ($urandom_range(99) < 10)
                    begin
                        if ($urandom_range(99) < 80)
                            aim_drv = int'($urandom_range(0, 800)) - 400;
                        else
                            aim_drv = int'($signed(FIELD_W'($urandom)));
                    end
                    spd = ($urandom_range(99) < 10) ? 30 : int'($urandom_range(30, 32767));
                    if ($urandom_range(1) == 1)
                        spd = -spd;
                    p.steer_request   = 1'b1;
                    p.power_steer_ok  = 1'b1;
                    p.standstill_flag = 1'b0;
                    p.speed_cms       = FIELD_W'(spd);
                    p.torque_given    = aim_given;
                    p.torque_request  = FIELD_W'(aim_torque);
                    p.steer_fraction  = FIELD_W'(aim_frac);
                    p.drv_torque      = FIELD_W'(aim_drv);
                end
                send_period(p, 1'b0, none);
                done++;
            end
        end

        // Drain, then allow for any stray beat
        period.valid <= 1'b0;
        while (torque_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        $display("Checked %0d steering periods across %0d register settings plus reset values.",
                 beats_in, NUM_PHASES);
        $display("Assist on in %0d periods, %0d enable drops, %0d hold nudges.",
                 assist_on, drops, nudges);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
